// ===== rtl/core/wavetable_hermite_oscillator_core_macros.svh =====
// assertion helpers shared by the core
`ifndef WAVETABLE_HERMITE_OSCILLATOR_CORE_MACROS_SVH
`define WAVETABLE_HERMITE_OSCILLATOR_CORE_MACROS_SVH

// same-cycle implication
`define WTHO_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTHO_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wtho_pkg.sv =====
package wtho_pkg;

    // table geometry and phase format
    localparam int TABLE_LENGTH = 2048;
    localparam int POS_W        = 11;
    localparam int FRAC_W       = 16;
    localparam int PHASE_W      = POS_W + FRAC_W;
    localparam int INC_W        = 26;
    localparam int SEL_W        = 3;
    localparam int WORD_W       = 16;
    localparam int GAIN_W       = 16;

    // interpolation datapath
    localparam int GUARD_W = 16;
    localparam int COEF_W  = 20;
    localparam int ACC_W   = 38;
    localparam int PROD_W  = ACC_W + FRAC_W + 1;
    localparam int GPROD_W = ACC_W + GAIN_W + 1;
    localparam int Y_W     = GPROD_W - 32;
    localparam logic signed [GPROD_W-1:0] ROUND_HALF =
        {{(GPROD_W-32){1'b0}}, 32'h8000_0000};

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

    // item kinds
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;
    localparam logic [1:0] ACT_START  = 2'd3;

    // register map, word index
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_TABLE_SEL = 2'd1;
    localparam logic [1:0] REG_MORPH_SEL = 2'd2;
    localparam logic [1:0] REG_GAIN      = 2'd3;

    typedef struct packed {
        logic [INC_W-1:0]  phase_inc;
        logic [SEL_W-1:0]  table_sel;
        logic [SEL_W-1:0]  morph_sel;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic step;
        logic scale;
    } interp_ctrl_t;

endpackage

// ===== rtl/core/wtho_ram.sv =====
module wtho_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/wtho_regs.sv =====
module wtho_regs
    import wtho_pkg::*;
#(
    parameter int MORPH_SLOTS = 8
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    cfg_t            cfg_reg;
    cfg_t            cfg_next;
    logic            wr_en;
    logic [SEL_W-1:0] morph_wr;

    assign wr_en = psel && penable && pwrite;

    // saturate morph slot at the last one
    always_comb begin
        if ({4'b0, pwdata[SEL_W-1:0]} > 7'(MORPH_SLOTS - 1)) begin
            morph_wr = SEL_W'(MORPH_SLOTS - 1);
        end else begin
            morph_wr = pwdata[SEL_W-1:0];
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_PHASE_INC: cfg_next.phase_inc = pwdata[INC_W-1:0];
                REG_TABLE_SEL: cfg_next.table_sel = pwdata[SEL_W-1:0];
                REG_MORPH_SEL: cfg_next.morph_sel = morph_wr;
                REG_GAIN:      cfg_next.gain      = pwdata[GAIN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_inc <= '0;
            cfg_reg.table_sel <= '0;
            cfg_reg.morph_sel <= '0;
            cfg_reg.gain      <= GAIN_UNITY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PHASE_INC: prdata = 32'(cfg_reg.phase_inc);
            REG_TABLE_SEL: prdata = 32'(cfg_reg.table_sel);
            REG_MORPH_SEL: prdata = 32'(cfg_reg.morph_sel);
            REG_GAIN:      prdata = 32'(cfg_reg.gain);
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/wtho_interp.sv =====
module wtho_interp
    import wtho_pkg::*;
(
    input  logic                     aclk,
    input  interp_ctrl_t             ctrl,
    input  logic signed [WORD_W-1:0] rdata,
    input  logic [FRAC_W-1:0]        frac,
    input  logic [GAIN_W-1:0]        gain,
    output logic signed [WORD_W-1:0] sample
);

    // window: [0] s(-1), [1] s(0), [2] s(1), [3] s(2)
    logic signed [WORD_W-1:0]  win_reg [4];
    // remaining horner coefficients, next one at [0]
    logic signed [COEF_W-1:0]  kq_reg [3];
    logic signed [ACC_W-1:0]   a_reg;
    logic signed [Y_W-1:0]     y_reg;

    logic signed [COEF_W-1:0]  sm1, s0, s1, s2;
    logic signed [COEF_W-1:0]  k0, k1, k2, k3;
    logic signed [COEF_W-1:0]  d03;
    logic signed [PROD_W-1:0]  prod;
    logic signed [GPROD_W-1:0] gmul;
    logic signed [GPROD_W-1:0] gsum;

    assign sm1 = COEF_W'(win_reg[0]);
    assign s0  = COEF_W'(win_reg[1]);
    assign s1  = COEF_W'(win_reg[2]);
    assign s2  = COEF_W'(win_reg[3]);

    // doubled hermite coefficients
    assign d03 = s0 - s1;
    assign k0  = s0 <<< 1;
    assign k1  = s1 - sm1;
    assign k2  = (sm1 <<< 1) - ((s0 <<< 2) + s0) + (s1 <<< 2) - s2;
    assign k3  = (s2 - sm1) + (d03 <<< 1) + d03;

    assign prod = a_reg * $signed({1'b0, frac});
    assign gmul = a_reg * $signed({1'b0, gain});
    assign gsum = gmul + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rdata;
        end
        if (ctrl.load) begin
            kq_reg[0] <= k2;
            kq_reg[1] <= k1;
            kq_reg[2] <= k0;
            a_reg     <= ACC_W'(k3) <<< GUARD_W;
        end else if (ctrl.step) begin
            kq_reg[0] <= kq_reg[1];
            kq_reg[1] <= kq_reg[2];
            kq_reg[2] <= kq_reg[2];
            a_reg     <= $signed(prod[ACC_W+FRAC_W-1:FRAC_W])
                         + (ACC_W'(kq_reg[0]) <<< GUARD_W);
        end
        if (ctrl.scale) begin
            y_reg <= gsum[GPROD_W-1:32];
        end
    end

    // saturate to 16 bits
    always_comb begin
        if (y_reg > Y_W'(32767)) begin
            sample = 16'sh7fff;
        end else if (y_reg < -Y_W'(32768)) begin
            sample = 16'sh8000;
        end else begin
            sample = y_reg[WORD_W-1:0];
        end
    end

endmodule

// ===== rtl/core/wavetable_hermite_oscillator_core.sv =====
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tuser: action; tdata: set, slot, address, word
// m_*       out  tvalid/tready      tdata: sample_out, playing
// apb       in   psel/penable       32-bit registers at 4*index, pready tied high
//
// a sample transaction makes four table reads through the single memory port, three
// horner steps on one multiplier, one gain step and one result write. a table write
// has a write step and the result step, stop/start only the result step.
// aresetn is synchronous, active low; table memory is not cleared and needs no pass.
// the input side stays open while a finished result waits on m_tready; a new
// result only stalls in its final step until the output register is free.

module wavetable_hermite_oscillator_core
    import wtho_pkg::*;
#(
    parameter int MORPH_SLOTS = 8,
    parameter int TABLE_SETS  = 8
)
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic [39:0] s_tdata,   // [2:0] table_set, [5:3] morph_slot,
                                   // [16:6] word_address, [32:17] word_value

    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] sample_out, [16] playing
);

`include "wavetable_hermite_oscillator_core_macros.svh"

    localparam int NTAB      = TABLE_SETS * MORPH_SLOTS;
    localparam int TIW       = NTAB > 1 ? $clog2(NTAB) : 1;
    localparam int MEM_DEPTH = NTAB * TABLE_LENGTH;
    localparam int MAW       = $clog2(MEM_DEPTH);
    localparam int IDX_W     = 13;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WR    = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_COEF  = 3'd4;
    localparam logic [2:0] ST_HORN  = 3'd5;
    localparam logic [2:0] ST_GAIN  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    localparam logic [1:0] RD_LAST   = 2'd3;
    localparam logic [1:0] HORN_LAST = 2'd2;

    cfg_t cfg;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               stopped_reg, stopped_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;

    // latched item payload
    logic [1:0]         act_reg;
    logic [SEL_W-1:0]   set_reg;
    logic [SEL_W-1:0]   slot_reg;
    logic [POS_W-1:0]   waddr_reg;
    logic [WORD_W-1:0]  wval_reg;

    logic               in_fire;
    logic               out_load;
    logic [IDX_W-1:0]   rd_set;
    logic [TIW-1:0]     rd_tbl;
    logic [TIW-1:0]     wr_tbl;
    logic               wr_ok;
    logic [POS_W-1:0]   rd_pos;
    logic [TIW+POS_W-1:0] addr_full;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_rdata;
    logic signed [WORD_W-1:0] interp_sample;
    logic [WORD_W-1:0]  sample_val;
    interp_ctrl_t       ictrl;

    assign pready = 1'b1;

    wtho_regs #(
        .MORPH_SLOTS (MORPH_SLOTS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // out-of-range set select reads the last set
    always_comb begin
        if (IDX_W'(cfg.table_sel) >= IDX_W'(TABLE_SETS)) begin
            rd_set = IDX_W'(TABLE_SETS - 1);
        end else begin
            rd_set = IDX_W'(cfg.table_sel);
        end
    end

    assign rd_tbl = TIW'(rd_set * IDX_W'(MORPH_SLOTS) + IDX_W'(cfg.morph_sel));
    assign wr_tbl = TIW'(IDX_W'(set_reg) * IDX_W'(MORPH_SLOTS) + IDX_W'(slot_reg));
    assign wr_ok  = (IDX_W'(set_reg) < IDX_W'(TABLE_SETS))
                 && (IDX_W'(slot_reg) < IDX_W'(MORPH_SLOTS));

    // window position: cnt 0..3 -> i-1 .. i+2, wraps in the table
    assign rd_pos = phase_reg[PHASE_W-1:FRAC_W] + POS_W'(cnt_reg) - POS_W'(1);

    assign mem_we    = (state_reg == ST_WR) && wr_ok;
    assign addr_full = (state_reg == ST_WR) ? {wr_tbl, waddr_reg} : {rd_tbl, rd_pos};

    wtho_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (mem_we),
        .addr  (addr_full[MAW-1:0]),
        .wdata (wval_reg),
        .rdata (mem_rdata)
    );

    assign ictrl.shift = rd_valid_reg;
    assign ictrl.load  = (state_reg == ST_COEF);
    assign ictrl.step  = (state_reg == ST_HORN);
    assign ictrl.scale = (state_reg == ST_GAIN);

    wtho_interp u_interp (
        .aclk   (aclk),
        .ctrl   (ictrl),
        .rdata  ($signed(mem_rdata)),
        .frac   (phase_reg[FRAC_W-1:0]),
        .gain   (cfg.gain),
        .sample (interp_sample)
    );

    assign out_load   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign sample_val = (act_reg == ACT_SAMPLE) ? interp_sample : '0;

    // sequencer and phase update
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_valid_next = 1'b0;
        phase_next    = phase_reg;
        stopped_next  = stopped_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cnt_next = '0;
                    case (s_tuser)
                        ACT_SAMPLE: state_next = ST_RD;
                        ACT_WRITE:  state_next = ST_WR;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end
            ST_WR: begin
                state_next = ST_FIN;
            end
            ST_RD: begin
                rd_valid_next = 1'b1;
                cnt_next      = cnt_reg + 2'd1;
                if (cnt_reg == RD_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COEF;
            end
            ST_COEF: begin
                cnt_next   = '0;
                state_next = ST_HORN;
            end
            ST_HORN: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == HORN_LAST) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    case (act_reg)
                        ACT_SAMPLE: begin
                            if (!stopped_reg) begin
                                phase_next = phase_reg + PHASE_W'(cfg.phase_inc);
                            end
                        end
                        ACT_STOP: begin
                            phase_next   = '0;
                            stopped_next = 1'b1;
                        end
                        ACT_START: begin
                            stopped_next = 1'b0;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0,
                                     !stopped_next && (cfg.phase_inc != '0),
                                     sample_val};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            phase_reg    <= '0;
            stopped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            phase_reg    <= phase_next;
            stopped_reg  <= stopped_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (in_fire) begin
            act_reg   <= s_tuser;
            set_reg   <= s_tdata[2:0];
            slot_reg  <= s_tdata[5:3];
            waddr_reg <= s_tdata[16:6];
            wval_reg  <= s_tdata[32:17];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a stopped oscillator always sits at phase zero
    `WTHO_ASSERT_NOW(a_stopped_phase, aclk, aresetn, stopped_reg, phase_reg == '0,
        "phase moved while stopped")

    // no table read still in flight when a new transaction can enter
    `WTHO_ASSERT_NOW(a_idle_no_read, aclk, aresetn, s_tready, !rd_valid_reg,
        "read pending while idle")

    // results of non-sample transactions carry a zero sample
    `WTHO_ASSERT_NEXT(a_zero_sample, aclk, aresetn, out_load && (act_reg != ACT_SAMPLE),
        m_tvalid && (m_tdata[15:0] == '0), "non-sample result carries data")

endmodule
